// File: rtl/core/npcb_pkg.sv
// shared constants and types for the nvme prp command builder
package npcb_pkg;

   localparam int REQ_TDATA_WIDTH = 256;
   localparam int RSP_TDATA_WIDTH = 304;

   localparam int PAGE_SHIFT = 12;
   localparam logic [63:0] PAGE_BYTES = 64'd4096;
   localparam logic [12:0] PAGE_SPAN = 13'd4096;
   localparam logic [18:0] PAGE_ROUND = 19'd4095;

   // wide enough for the largest page count of one request and the largest list
   localparam int EXTRA_WIDTH = 7;

   localparam logic [1:0] OPC_WRITE = 2'd1;
   localparam logic [1:0] OPC_READ = 2'd2;

   localparam logic KIND_COMMAND = 1'b0;
   localparam logic KIND_LIST = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CALC = 4'b0010,
      ST_CMD  = 4'b0100,
      ST_LIST = 4'b1000
   } state_type;

endpackage

// File: rtl/core/nvme_prp_command_builder.sv
// nvme prp command builder: request in, submission command and prp list entries out
// One request is taken when the block is idle. The next cycle sizes the transfer and forms
// the first extra page address; then the command transaction is offered, followed by one
// prp list transaction per extra page when the buffer spans more than two pages (capped at
// MAX_LIST_ENTRIES). A single 64-bit page adder, shared between the setup step and the list
// walk, produces every page address.
module nvme_prp_command_builder #(
   parameter int MAX_LIST_ENTRIES = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // namespace_id, start_lba, block_count, buffer_address, byte_count, list_page_address
   input  logic [npcb_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   // write_request
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // opcode, command_namespace, prp_first, prp_second, command_lba, blocks_minus_one,
   // list_entry, list_index
   output logic [npcb_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // item_kind
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast
);

   localparam int CW = $clog2(MAX_LIST_ENTRIES + 1);
   localparam logic [npcb_pkg::EXTRA_WIDTH-1:0] MaxEntries =
      npcb_pkg::EXTRA_WIDTH'(MAX_LIST_ENTRIES);

   npcb_pkg::state_type state_ff, state_in;

   logic        write_ff, write_in;
   logic [31:0] ns_ff, ns_in;
   logic [63:0] lba_ff, lba_in;
   logic [7:0]  bmo_ff, bmo_in;
   logic [63:0] addr_ff, addr_in;
   logic [17:0] bytes_ff, bytes_in;
   logic [63:0] list_ff, list_in;
   logic [63:0] prp2_ff, prp2_in;
   logic [63:0] page_ff, page_in;
   logic [CW-1:0] entries_ff, entries_in;
   logic [CW-1:0] idx_ff, idx_in;

   logic [63:0] adder_a;
   logic [63:0] adder_out;
   logic [12:0] first_bytes;
   logic [17:0] rest;
   logic [18:0] rest_round;
   logic [npcb_pkg::EXTRA_WIDTH-1:0] extra;
   logic [CW+4:0] idx_wide;
   logic        list_last;
   logic        rsp_fire;

   // shared page adder
   assign adder_a = (state_ff == npcb_pkg::ST_CALC) ?
                    {addr_ff[63:npcb_pkg::PAGE_SHIFT], {npcb_pkg::PAGE_SHIFT{1'b0}}} :
                    page_ff;
   assign adder_out = adder_a + npcb_pkg::PAGE_BYTES;

   assign first_bytes = npcb_pkg::PAGE_SPAN - {1'b0, addr_ff[npcb_pkg::PAGE_SHIFT-1:0]};
   assign rest = bytes_ff - {5'd0, first_bytes};
   assign rest_round = {1'b0, rest} + npcb_pkg::PAGE_ROUND;
   assign extra = npcb_pkg::EXTRA_WIDTH'(rest_round >> npcb_pkg::PAGE_SHIFT);

   assign idx_wide = {5'd0, idx_ff};
   assign list_last = ((idx_ff + CW'(1)) == entries_ff);

   assign req_tready = (state_ff == npcb_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == npcb_pkg::ST_CMD) || (state_ff == npcb_pkg::ST_LIST);
   assign rsp_fire = rsp_tvalid && rsp_tready;

   always_comb begin
      state_in = state_ff;
      write_in = write_ff;
      ns_in = ns_ff;
      lba_in = lba_ff;
      bmo_in = bmo_ff;
      addr_in = addr_ff;
      bytes_in = bytes_ff;
      list_in = list_ff;
      prp2_in = prp2_ff;
      page_in = page_ff;
      entries_in = entries_ff;
      idx_in = idx_ff;
      case (state_ff)
         npcb_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               write_in = req_tuser;
               ns_in = req_tdata[31:0];
               lba_in = req_tdata[95:32];
               bmo_in = req_tdata[103:96] - 8'd1;
               addr_in = req_tdata[168:105];
               bytes_in = req_tdata[186:169];
               list_in = req_tdata[250:187];
               state_in = npcb_pkg::ST_CALC;
            end
         end
         npcb_pkg::ST_CALC: begin
            page_in = adder_out;
            idx_in = '0;
            prp2_in = '0;
            entries_in = '0;
            if (bytes_ff > {5'd0, first_bytes}) begin
               if (extra == npcb_pkg::EXTRA_WIDTH'(1)) begin
                  prp2_in = adder_out;
               end else begin
                  prp2_in = list_ff;
                  entries_in = (extra > MaxEntries) ? CW'(MAX_LIST_ENTRIES) : CW'(extra);
               end
            end
            state_in = npcb_pkg::ST_CMD;
         end
         npcb_pkg::ST_CMD: begin
            if (rsp_fire) begin
               state_in = (entries_ff == '0) ? npcb_pkg::ST_IDLE : npcb_pkg::ST_LIST;
            end
         end
         npcb_pkg::ST_LIST: begin
            if (rsp_fire) begin
               page_in = adder_out;
               idx_in = idx_ff + CW'(1);
               if (list_last) begin
                  state_in = npcb_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = npcb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= npcb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      write_ff <= write_in;
      ns_ff <= ns_in;
      lba_ff <= lba_in;
      bmo_ff <= bmo_in;
      addr_ff <= addr_in;
      bytes_ff <= bytes_in;
      list_ff <= list_in;
      prp2_ff <= prp2_in;
      page_ff <= page_in;
      entries_ff <= entries_in;
      idx_ff <= idx_in;
   end

   always_comb begin
      rsp_tdata = '0;
      if (state_ff == npcb_pkg::ST_LIST) begin
         rsp_tuser = npcb_pkg::KIND_LIST;
         rsp_tlast = list_last;
         rsp_tdata[297:234] = page_ff;
         rsp_tdata[302:298] = idx_wide[4:0];
      end else begin
         rsp_tuser = npcb_pkg::KIND_COMMAND;
         rsp_tlast = (entries_ff == '0);
         rsp_tdata[1:0] = write_ff ? npcb_pkg::OPC_WRITE : npcb_pkg::OPC_READ;
         rsp_tdata[33:2] = ns_ff;
         rsp_tdata[97:34] = addr_ff;
         rsp_tdata[161:98] = prp2_ff;
         rsp_tdata[225:162] = lba_ff;
         rsp_tdata[233:226] = bmo_ff;
      end
   end

endmodule
